>>> src/mck_pkg.sv
// Shared types, constants and the Morse code table for the keyer.
package mck_pkg;

    localparam int unsigned UNIT_W = 16;
    localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd150;

    localparam logic [2:0] MAX_SYMBOLS   = 3'd5;
    localparam logic [2:0] DOT_UNITS     = 3'd1;
    localparam logic [2:0] DASH_UNITS    = 3'd3;
    localparam logic [2:0] SYMOFF_UNITS  = 3'd1;
    localparam logic [2:0] END_GAP_UNITS = 3'd2;
    localparam logic [2:0] SPACE_UNITS   = 3'd4;

    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
    } in_beat_t;

    typedef struct packed {
        logic key_level;
        logic busy_res;
        logic rejected;
    } out_beat_t;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_SPACE,
        CMD_CHAR,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        logic [2:0] len;
        logic [4:0] pat;
    } code_t;

    typedef struct packed {
        cmd_kind_t kind;
        code_t     code;
    } cmd_t;

    // Letters A..Z at 0..25, digits 0..9 at 26..35; first symbol in bit 0, 1 = dash.
    function automatic code_t code_lookup(input logic [5:0] idx);
        code_t c;
        unique case (idx)
            6'd0:  c = '{3'd2, 5'd2};
            6'd1:  c = '{3'd4, 5'd1};
            6'd2:  c = '{3'd4, 5'd5};
            6'd3:  c = '{3'd3, 5'd1};
            6'd4:  c = '{3'd1, 5'd0};
            6'd5:  c = '{3'd4, 5'd4};
            6'd6:  c = '{3'd3, 5'd3};
            6'd7:  c = '{3'd4, 5'd0};
            6'd8:  c = '{3'd2, 5'd0};
            6'd9:  c = '{3'd4, 5'd14};
            6'd10: c = '{3'd3, 5'd5};
            6'd11: c = '{3'd4, 5'd2};
            6'd12: c = '{3'd2, 5'd3};
            6'd13: c = '{3'd2, 5'd1};
            6'd14: c = '{3'd3, 5'd7};
            6'd15: c = '{3'd4, 5'd6};
            6'd16: c = '{3'd4, 5'd11};
            6'd17: c = '{3'd3, 5'd2};
            6'd18: c = '{3'd3, 5'd0};
            6'd19: c = '{3'd1, 5'd1};
            6'd20: c = '{3'd3, 5'd4};
            6'd21: c = '{3'd4, 5'd8};
            6'd22: c = '{3'd3, 5'd6};
            6'd23: c = '{3'd4, 5'd9};
            6'd24: c = '{3'd4, 5'd13};
            6'd25: c = '{3'd4, 5'd3};
            6'd26: c = '{3'd5, 5'd31};
            6'd27: c = '{3'd5, 5'd30};
            6'd28: c = '{3'd5, 5'd28};
            6'd29: c = '{3'd5, 5'd24};
            6'd30: c = '{3'd5, 5'd16};
            6'd31: c = '{3'd5, 5'd0};
            6'd32: c = '{3'd5, 5'd1};
            6'd33: c = '{3'd5, 5'd3};
            6'd34: c = '{3'd5, 5'd7};
            6'd35: c = '{3'd5, 5'd15};
            default: c = '{3'd0, 5'd0};
        endcase
        return c;
    endfunction

endpackage

>>> src/mck_fifo.sv
// Small first-in first-out queue with count-based full and empty flags.
module mck_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> src/mck_front.sv
// Front end: takes input beats, classifies characters and queues commands.
module mck_front import mck_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_beat_t item,
    output logic     full,
    input  logic     cmd_pop,
    output cmd_t     cmd,
    output logic     cmd_empty
);

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_9     = 8'h39;
    localparam logic [7:0] ASCII_UA    = 8'h41;
    localparam logic [7:0] ASCII_UZ    = 8'h5A;
    localparam logic [7:0] ASCII_LA    = 8'h61;
    localparam logic [7:0] ASCII_LZ    = 8'h7A;
    localparam logic [7:0] DIGIT_BASE  = 8'd26;

    cmd_t       cmd_in;
    logic [7:0] idx_wide;
    logic       known;
    code_t      code;
    logic [$bits(cmd_t)-1:0] cmd_bits;

    always_comb
    begin
        idx_wide = '0;
        known    = 1'b1;
        priority if (item.char_code >= ASCII_LA && item.char_code <= ASCII_LZ)
        begin
            idx_wide = item.char_code - ASCII_LA;
        end
        else if (item.char_code >= ASCII_UA && item.char_code <= ASCII_UZ)
        begin
            idx_wide = item.char_code - ASCII_UA;
        end
        else if (item.char_code >= ASCII_0 && item.char_code <= ASCII_9)
        begin
            idx_wide = item.char_code - ASCII_0 + DIGIT_BASE;
        end
        else
        begin
            known = 1'b0;
        end

        code = code_lookup(idx_wide[5:0]);
        // clamp to the longest pattern the back end can shift out
        if (code.len > MAX_SYMBOLS)
        begin
            code.len = MAX_SYMBOLS;
        end

        cmd_in.code = code;
        priority if (item.func == FUNC_TICK)
        begin
            cmd_in.kind = CMD_TICK;
        end
        else if (item.char_code == ASCII_SPACE)
        begin
            cmd_in.kind = CMD_SPACE;
        end
        else if (known)
        begin
            cmd_in.kind = CMD_CHAR;
        end
        else
        begin
            cmd_in.kind = CMD_BAD;
        end
    end

    mck_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_bits),
        .empty (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_bits);

endmodule

>>> src/mck_back.sv
// Back end: timing state machine that keys the line and queues result beats.
module mck_back import mck_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [UNIT_W-1:0] unit_ticks,
    input  cmd_t              cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    output out_beat_t         result,
    output logic              empty,
    input  logic              pop
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MARK,
        PH_SYMOFF,
        PH_GAP
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [UNIT_W-1:0] tick_count_reg, tick_count_next;
    logic [2:0]        units_left_reg, units_left_next;
    logic [4:0]        pattern_reg, pattern_next;
    logic [2:0]        symbols_left_reg, symbols_left_next;
    logic              key_reg, key_next;
    logic              rej;
    logic [UNIT_W-1:0] tick_inc;
    logic [2:0]        units_dec;
    logic              res_full;
    logic              step;
    out_beat_t         res_in;
    logic [$bits(out_beat_t)-1:0] res_bits;

    assign step    = !cmd_empty && !res_full;
    assign cmd_pop = step;

    always_comb
    begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        units_left_next   = units_left_reg;
        pattern_next      = pattern_reg;
        symbols_left_next = symbols_left_reg;
        key_next          = key_reg;
        rej               = 1'b0;
        tick_inc          = tick_count_reg + 1'b1;
        units_dec         = units_left_reg - 1'b1;

        unique case (cmd.kind)
            CMD_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= unit_ticks)
                    begin
                        tick_count_next = '0;
                        units_left_next = units_dec;
                        if (units_dec == '0)
                        begin
                            // segment over: advance to the next segment, or to idle after the gap
                            unique case (phase_reg)
                                PH_MARK:
                                begin
                                    phase_next      = PH_SYMOFF;
                                    key_next        = 1'b0;
                                    units_left_next = SYMOFF_UNITS;
                                end
                                PH_SYMOFF:
                                begin
                                    if (symbols_left_reg != '0)
                                    begin
                                        phase_next        = PH_MARK;
                                        key_next          = 1'b1;
                                        pattern_next      = {1'b0, pattern_reg[4:1]};
                                        symbols_left_next = symbols_left_reg - 1'b1;
                                        units_left_next   = pattern_reg[0] ? DASH_UNITS
                                                                           : DOT_UNITS;
                                    end
                                    else
                                    begin
                                        phase_next      = PH_GAP;
                                        key_next        = 1'b0;
                                        units_left_next = END_GAP_UNITS;
                                    end
                                end
                                default:
                                begin
                                    phase_next      = PH_IDLE;
                                    key_next        = 1'b0;
                                    units_left_next = '0;
                                end
                            endcase
                        end
                    end
                end
            end
            CMD_SPACE:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    phase_next        = PH_GAP;
                    key_next          = 1'b0;
                    units_left_next   = SPACE_UNITS;
                    tick_count_next   = '0;
                    symbols_left_next = '0;
                    pattern_next      = '0;
                end
            end
            CMD_CHAR:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    // start the first symbol straight away
                    phase_next        = PH_MARK;
                    key_next          = 1'b1;
                    pattern_next      = {1'b0, cmd.code.pat[4:1]};
                    symbols_left_next = cmd.code.len - 1'b1;
                    units_left_next   = cmd.code.pat[0] ? DASH_UNITS : DOT_UNITS;
                    tick_count_next   = '0;
                end
            end
            CMD_BAD:
            begin
                rej = 1'b1;
            end
        endcase

        res_in.key_level = key_next;
        res_in.busy_res  = (phase_next != PH_IDLE);
        res_in.rejected  = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_count_reg   <= '0;
            units_left_reg   <= '0;
            pattern_reg      <= '0;
            symbols_left_reg <= '0;
            key_reg          <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            units_left_reg   <= units_left_next;
            pattern_reg      <= pattern_next;
            symbols_left_reg <= symbols_left_next;
            key_reg          <= key_next;
        end
    end

    mck_fifo #(
        .WIDTH ($bits(out_beat_t)),
        .DEPTH (DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (step),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign result = out_beat_t'(res_bits);

endmodule

>>> src/morse_code_keyer_core.sv
// Morse code keyer top level: config register, front end and back end.
//
// Input channel: an item (func, char_code) is taken when push is high and full
// is low. func = 1 is one time tick; func = 0 is an ASCII character to key.
// Result channel: one result beat per item (key_level, busy_res, rejected),
// presented while empty is low and taken when pop is high.
// Config: unit_ticks (ticks per Morse unit, reset 150) at address 0 over the
// APB port; write it only while no item is in flight.
// Path: a taken item is written into the command queue; the back end
// retires the command when the result queue has room and writes its result
// there, where it shows on the result ports until it is popped.
// Throughput: one item per cycle while full is low; the back end state update retires one
// command per cycle whenever the result queue has room.
// Reset clears both queues, puts the keyer in idle with the line off and
// loads the default unit length. When the receiver stops popping, the
// result queue fills, the back end holds, the command queue fills and full
// rises; nothing is dropped.
module morse_code_keyer_core import mck_pkg::*; #(
    parameter int unsigned CMD_DEPTH = 2,
    parameter int unsigned RES_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  in_beat_t    item,
    output logic        full,
    output out_beat_t   result,
    output logic        empty,
    input  logic        pop,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [UNIT_W-1:0] unit_ticks_reg;
    logic              cfg_wr;
    cmd_t              cmd;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              addr_hit;

    assign pready   = 1'b1;
    // only one register: every word address in the decoded range selects it
    assign addr_hit = (paddr[1:0] == 2'b00) || (paddr[1:0] != 2'b00);
    assign cfg_wr   = psel && penable && pwrite && pready && addr_hit;
    assign prdata   = {{(32 - UNIT_W){1'b0}}, unit_ticks_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UNIT_TICKS_RESET;
        end
        else if (cfg_wr)
        begin
            unit_ticks_reg <= pwdata[UNIT_W-1:0];
        end
    end

    mck_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    mck_back #(
        .DEPTH (RES_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_ticks (unit_ticks_reg),
        .cmd        (cmd),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule
